[src/tcp_hop_pkg.sv]
// ----------------------------------------------------------------------------
// tcp_hop_pkg
// Shared types, codes and constants of the TCP header and option parser.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_hop_pkg;

  localparam int MAX_OPTION_BYTES   = 40;
  localparam int FIXED_HEADER_BYTES = 20;
  localparam int KNOWN_KINDS        = 9;
  localparam int FIFO_DEPTH         = 4;
  localparam int FIFO_AW            = $clog2(FIFO_DEPTH);

  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam logic [5:0]  REC_MAX = 6'd63;
  localparam logic [3:0]  MIN_OFFSET_WORDS = 4'd5;
  localparam logic [7:0]  KIND_LEN_BYTES = 8'd2;

  localparam logic KIND_OPTION  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_SHORT     = 2'd1;
  localparam logic [1:0] ST_BAD_OFF   = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  localparam logic [7:0] OPT_EOL = 8'd0;
  localparam logic [7:0] OPT_NOP = 8'd1;

  // expected total option length per known kind, 0 = single byte or variable
  localparam logic [7:0] EXPECT_LEN [KNOWN_KINDS] = '{
    8'd0, 8'd0, 8'd4, 8'd3, 8'd2, 8'd0, 8'd6, 8'd6, 8'd10
  };

  typedef enum logic [1:0] {
    PH_KIND,
    PH_LEN,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  option_type;
    logic [7:0]  option_len;
    logic [5:0]  value_offset;
    logic [5:0]  option_index;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [5:0]  header_len;
    logic [1:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

[src/tcp_header_option_parser.sv]
// ----------------------------------------------------------------------------
// tcp_header_option_parser
// Byte-stream TCP header and option parser with a small result queue.
// ----------------------------------------------------------------------------
// One segment byte is taken per beat, header byte zero first, tlast on the
// final byte. Each byte is parsed in the cycle it is accepted and yields zero,
// one or two results (an option record, then the header summary), which go
// into a four-entry result queue. A new byte is taken in every cycle while the
// queue has two free entries, so the sustained rate is one byte per cycle as
// long as the output side drains one result per cycle; the output beat rate
// of the queue sets the figure. Results carry tuser = 0 for an option record
// and tuser = 1 for the header summary; tlast marks the last result of a byte.
`default_nettype none

module tcp_header_option_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // last_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // [7:0] option_type, [15:8] option_len,
                                  // [21:16] value_offset, [27:22] option_index,
                                  // [43:28] source_port, [59:44] destination_port,
                                  // [65:60] header_len, [67:66] status, zero fill
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last
);

  tcp_hop_pkg::push_t   push;
  tcp_hop_pkg::result_t res;
  logic                 accept;
  logic                 space_ok;

  assign in_tready = space_ok;
  assign accept    = in_tvalid && space_ok;

  tcp_hop_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .push      (push)
  );

  tcp_hop_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (accept),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {4'd0, res.status, res.header_len, res.destination_port,
                      res.source_port, res.option_index, res.value_offset,
                      res.option_len, res.option_type};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire

[src/tcp_hop_fifo.sv]
// ----------------------------------------------------------------------------
// tcp_hop_fifo
// Result queue: takes up to two results per cycle, delivers one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_hop_fifo (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push_en,
  input  wire tcp_hop_pkg::push_t push,
  output logic                  space_ok,
  output logic                  out_valid,
  input  wire                   out_ready,
  output tcp_hop_pkg::result_t  out_res
);

  localparam int AW = tcp_hop_pkg::FIFO_AW;

  tcp_hop_pkg::result_t mem [tcp_hop_pkg::FIFO_DEPTH];

  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [1:0]    n_push;
  logic          pop;

  assign n_push    = push_en ? push.cnt : 2'd0;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign out_res   = mem[rp_r];
  assign space_ok  = (cnt_r <= (AW+1)'(tcp_hop_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + AW'(n_push);
    rp_nxt  = rp_r + AW'(pop);
    cnt_nxt = cnt_r + (AW+1)'(n_push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wp_r] <= push.r0;
    end
    if (n_push == 2'd2) begin
      mem[wp_r + AW'(1)] <= push.r1;
    end
  end

endmodule

`default_nettype wire

[src/tcp_hop_core.sv]
// ----------------------------------------------------------------------------
// tcp_hop_core
// Per-byte header capture, option walk and summary generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_hop_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 accept,
  input  wire  [7:0]          data_byte,
  input  wire                 last_byte,
  output tcp_hop_pkg::push_t  push
);

  logic [15:0] pos_r, pos_nxt;
  logic [31:0] pp_r, pp_nxt;
  logic [3:0]  ow_r, ow_nxt;
  tcp_hop_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [5:0]  rec_r, rec_nxt;
  logic        abort_r, abort_nxt;
  logic        sent_r, sent_nxt;

  logic [5:0]  hlen;
  logic [5:0]  voff;
  logic [7:0]  vlen;
  logic [7:0]  exp_len;
  logic        known, in_opts, opt_v, sum_v, ow_ok;
  logic [1:0]  sum_st;
  logic [7:0]  opt_type, opt_len;
  logic [5:0]  opt_voff;
  tcp_hop_pkg::result_t opt_r, sum_r;

  always_comb begin
    pp_nxt  = (pos_r < 16'd4) ? {pp_r[23:0], data_byte} : pp_r;
    ow_nxt  = (pos_r == 16'd12) ? data_byte[7:4] : ow_r;
    hlen    = {ow_nxt, 2'b00};
    ow_ok   = (ow_nxt >= tcp_hop_pkg::MIN_OFFSET_WORDS);
    in_opts = !sent_r && !abort_r && ow_ok &&
              ({1'b0, hlen} <= 7'(tcp_hop_pkg::FIXED_HEADER_BYTES +
                                  tcp_hop_pkg::MAX_OPTION_BYTES)) &&
              (pos_r >= 16'(tcp_hop_pkg::FIXED_HEADER_BYTES)) &&
              (pos_r < {10'd0, hlen});

    known   = (pend_r < 8'(tcp_hop_pkg::KNOWN_KINDS));
    exp_len = known ? tcp_hop_pkg::EXPECT_LEN[pend_r[3:0]] : 8'd0;
    vlen    = data_byte - tcp_hop_pkg::KIND_LEN_BYTES;
    voff    = pos_r[5:0] + 6'd1;

    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    skip_nxt  = skip_r;
    abort_nxt = abort_r;
    opt_v     = 1'b0;
    opt_type  = data_byte;
    opt_len   = 8'd0;
    opt_voff  = 6'd0;

    if (in_opts) begin
      unique case (phase_r)
        tcp_hop_pkg::PH_KIND: begin
          if (data_byte <= tcp_hop_pkg::OPT_NOP) begin
            opt_v = 1'b1;
          end else begin
            pend_nxt  = data_byte;
            phase_nxt = tcp_hop_pkg::PH_LEN;
          end
        end
        tcp_hop_pkg::PH_LEN: begin
          if (data_byte < tcp_hop_pkg::KIND_LEN_BYTES ||
              (exp_len != 8'd0 && data_byte != exp_len)) begin
            abort_nxt = 1'b1;
          end else begin
            opt_v    = known;
            opt_type = pend_r;
            opt_len  = vlen;
            opt_voff = (vlen != 8'd0) ? voff : 6'd0;
            if (vlen != 8'd0) begin
              skip_nxt  = vlen;
              phase_nxt = tcp_hop_pkg::PH_SKIP;
            end else begin
              phase_nxt = tcp_hop_pkg::PH_KIND;
            end
          end
        end
        tcp_hop_pkg::PH_SKIP: begin
          if (skip_r <= 8'd1) begin
            skip_nxt  = 8'd0;
            phase_nxt = tcp_hop_pkg::PH_KIND;
          end else begin
            skip_nxt = skip_r - 8'd1;
          end
        end
        default: phase_nxt = tcp_hop_pkg::PH_KIND;
      endcase
    end

    rec_nxt = (opt_v && rec_r != tcp_hop_pkg::REC_MAX) ? rec_r + 6'd1 : rec_r;

    sum_v  = 1'b0;
    sum_st = tcp_hop_pkg::ST_OK;
    if (!sent_r) begin
      if (pos_r == 16'(tcp_hop_pkg::FIXED_HEADER_BYTES - 1) && !ow_ok) begin
        sum_v  = 1'b1;
        sum_st = tcp_hop_pkg::ST_BAD_OFF;
      end else if (ow_ok && pos_r >= 16'(tcp_hop_pkg::FIXED_HEADER_BYTES - 1) &&
                   pos_r == {10'd0, hlen - 6'd1}) begin
        sum_v  = 1'b1;
        sum_st = tcp_hop_pkg::ST_OK;
      end else if (last_byte) begin
        sum_v  = 1'b1;
        sum_st = (pos_r < 16'(tcp_hop_pkg::FIXED_HEADER_BYTES - 1)) ?
                 tcp_hop_pkg::ST_SHORT : tcp_hop_pkg::ST_TRUNCATED;
      end
    end
    sent_nxt = sent_r || sum_v;

    opt_r              = '0;
    opt_r.kind         = tcp_hop_pkg::KIND_OPTION;
    opt_r.option_type  = opt_type;
    opt_r.option_len   = opt_len;
    opt_r.value_offset = opt_voff;
    opt_r.option_index = rec_r;
    opt_r.last         = !sum_v;

    sum_r        = '0;
    sum_r.kind   = tcp_hop_pkg::KIND_SUMMARY;
    sum_r.status = sum_st;
    sum_r.last   = 1'b1;
    if (sum_st != tcp_hop_pkg::ST_SHORT) begin
      sum_r.source_port      = pp_nxt[31:16];
      sum_r.destination_port = pp_nxt[15:0];
      sum_r.header_len       = hlen;
    end

    push.cnt = {1'b0, opt_v} + {1'b0, sum_v};
    push.r0  = opt_v ? opt_r : sum_r;
    push.r1  = sum_r;

    pos_nxt = (pos_r != tcp_hop_pkg::POS_MAX) ? pos_r + 16'd1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      pos_r   <= '0;
      pp_r    <= '0;
      ow_r    <= '0;
      phase_r <= tcp_hop_pkg::PH_KIND;
      pend_r  <= '0;
      skip_r  <= '0;
      rec_r   <= '0;
      abort_r <= 1'b0;
      sent_r  <= 1'b0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      pp_r    <= pp_nxt;
      ow_r    <= ow_nxt;
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      skip_r  <= skip_nxt;
      rec_r   <= rec_nxt;
      abort_r <= abort_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

`default_nettype wire

[tb/tcp_parse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcp_parse_checker
// Follows every byte beat into the parser, works out the option records and
// the header summary that byte should give, and checks each result beat
// against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------

module tcp_parse_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // last_byte
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire  [71:0] out_tdata,  // [7:0] option_type, [15:8] option_len,
                                  // [21:16] value_offset, [27:22] option_index,
                                  // [43:28] source_port, [59:44] destination_port,
                                  // [65:60] header_len, [67:66] status, zero fill
  input  wire         out_tuser,  // kind
  input  wire         out_tlast,  // last
  output int          mismatches,
  output int          results_owed
);

  // parser state as seen from the stream
  logic [15:0]         pos_q;
  logic [31:0]         ports_q;
  logic [3:0]          offw_q;
  tcp_hop_pkg::phase_t phase_q;
  logic [7:0]          kind_q;
  logic [7:0]          skip_q;
  logic [5:0]          rec_q;
  logic                abort_q;
  logic                summ_q;

  tcp_hop_pkg::result_t owed_q [$];
  tcp_hop_pkg::result_t made [2];
  int                   made_n;
  int                   errs = 0;

  task automatic clear_state();
    pos_q   = '0;
    ports_q = '0;
    offw_q  = '0;
    phase_q = tcp_hop_pkg::PH_KIND;
    kind_q  = '0;
    skip_q  = '0;
    rec_q   = '0;
    abort_q = 1'b0;
    summ_q  = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [71:0] got,
                                 input logic [71:0] want);
    $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errs++;
  endtask

  task automatic check_field(input string what, input logic [71:0] got,
                             input logic [71:0] want);
    if (got !== want)
      report_mismatch(what, got, want);
  endtask

  task automatic add_option(input logic [7:0] t, input logic [7:0] len,
                            input logic [5:0] voff);
    tcp_hop_pkg::result_t r;
    r              = '0;
    r.kind         = tcp_hop_pkg::KIND_OPTION;
    r.option_type  = t;
    r.option_len   = len;
    r.value_offset = voff;
    r.option_index = rec_q;
    if (rec_q != tcp_hop_pkg::REC_MAX)
      rec_q = rec_q + 6'd1;
    made[made_n] = r;
    made_n++;
  endtask

  task automatic add_summary(input logic [1:0] st);
    tcp_hop_pkg::result_t r;
    r        = '0;
    r.kind   = tcp_hop_pkg::KIND_SUMMARY;
    r.status = st;
    if (st != tcp_hop_pkg::ST_SHORT) begin
      r.source_port      = ports_q[31:16];
      r.destination_port = ports_q[15:0];
      r.header_len       = {offw_q, 2'b00};
    end
    summ_q = 1'b1;
    made[made_n] = r;
    made_n++;
  endtask

  task automatic walk_option(input logic [15:0] pos, input logic [7:0] b);
    logic       known;
    logic [7:0] fixed_len;
    logic [7:0] vlen;
    if (phase_q == tcp_hop_pkg::PH_KIND) begin
      if (b == tcp_hop_pkg::OPT_EOL || b == tcp_hop_pkg::OPT_NOP) begin
        add_option(b, 8'd0, 6'd0);
      end else begin
        kind_q  = b;
        phase_q = tcp_hop_pkg::PH_LEN;
      end
    end else if (phase_q == tcp_hop_pkg::PH_LEN) begin
      known     = kind_q < tcp_hop_pkg::KNOWN_KINDS;
      fixed_len = known ? tcp_hop_pkg::EXPECT_LEN[kind_q] : 8'd0;
      if (b < tcp_hop_pkg::KIND_LEN_BYTES) begin
        abort_q = 1'b1;
      end else if (fixed_len != 8'd0 && b != fixed_len) begin
        abort_q = 1'b1;
      end else begin
        vlen = b - tcp_hop_pkg::KIND_LEN_BYTES;
        if (known)
          add_option(kind_q, vlen, (vlen != 8'd0) ? pos[5:0] + 6'd1 : 6'd0);
        if (vlen != 8'd0) begin
          skip_q  = vlen;
          phase_q = tcp_hop_pkg::PH_SKIP;
        end else begin
          phase_q = tcp_hop_pkg::PH_KIND;
        end
      end
    end else begin
      if (skip_q <= 8'd1) begin
        skip_q  = 8'd0;
        phase_q = tcp_hop_pkg::PH_KIND;
      end else begin
        skip_q = skip_q - 8'd1;
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lastb);
    logic [15:0]          pos;
    int                   hlen;
    tcp_hop_pkg::result_t r;
    pos    = pos_q;
    made_n = 0;
    if (pos < 4)
      ports_q = {ports_q[23:0], b};
    if (pos == 12)
      offw_q = b[7:4];
    hlen = offw_q * 4;

    if (!summ_q && !abort_q && offw_q >= tcp_hop_pkg::MIN_OFFSET_WORDS &&
        hlen - tcp_hop_pkg::FIXED_HEADER_BYTES <= tcp_hop_pkg::MAX_OPTION_BYTES &&
        pos >= tcp_hop_pkg::FIXED_HEADER_BYTES && pos < hlen)
      walk_option(pos, b);

    if (!summ_q) begin
      if (pos == tcp_hop_pkg::FIXED_HEADER_BYTES - 1 &&
          offw_q < tcp_hop_pkg::MIN_OFFSET_WORDS)
        add_summary(tcp_hop_pkg::ST_BAD_OFF);
      else if (offw_q >= tcp_hop_pkg::MIN_OFFSET_WORDS &&
               pos >= tcp_hop_pkg::FIXED_HEADER_BYTES - 1 && pos == hlen - 1)
        add_summary(tcp_hop_pkg::ST_OK);
      else if (lastb)
        add_summary((pos < tcp_hop_pkg::FIXED_HEADER_BYTES - 1) ?
                    tcp_hop_pkg::ST_SHORT : tcp_hop_pkg::ST_TRUNCATED);
    end

    if (made_n > 0) begin
      r            = made[made_n - 1];
      r.last       = 1'b1;
      made[made_n - 1] = r;
    end
    for (int i = 0; i < made_n; i++)
      owed_q.push_back(made[i]);

    if (lastb)
      clear_state();
    else if (pos_q != tcp_hop_pkg::POS_MAX)
      pos_q = pos_q + 16'd1;
  endtask

  always @(posedge clk) begin
    tcp_hop_pkg::result_t want;
    if (!rst_n) begin
      clear_state();
      owed_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          report_mismatch("result beat with nothing pending", out_tdata, '0);
        end else begin
          want = owed_q.pop_front();
          check_field("kind", out_tuser, want.kind);
          check_field("option_type", out_tdata[7:0], want.option_type);
          check_field("option_len", out_tdata[15:8], want.option_len);
          check_field("value_offset", out_tdata[21:16], want.value_offset);
          check_field("option_index", out_tdata[27:22], want.option_index);
          check_field("source_port", out_tdata[43:28], want.source_port);
          check_field("destination_port", out_tdata[59:44], want.destination_port);
          check_field("header_len", out_tdata[65:60], want.header_len);
          check_field("status", out_tdata[67:66], want.status);
          check_field("tdata fill", out_tdata[71:68], 4'h0);
          check_field("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready)
        parse_byte(in_tdata, in_tlast);
    end
    mismatches   <= errs;
    results_owed <= owed_q.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds TCP segments byte by byte into the header and option parser: a few
// hand-built segments for the corner cases, then mostly well-formed random
// headers with random options, plus broken, truncated and noise segments.
// Sender bursts and receiver stalls are random; the checker does the scoring.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1150;
  localparam int SEG_CAP      = 72;

  localparam logic [7:0] OPT_MSS        = 8'd2;
  localparam logic [7:0] OPT_WSCALE     = 8'd3;
  localparam logic [7:0] OPT_SACK_OK    = 8'd4;
  localparam logic [7:0] OPT_SACK       = 8'd5;
  localparam logic [7:0] OPT_ECHO       = 8'd6;
  localparam logic [7:0] OPT_ECHO_REPLY = 8'd7;
  localparam logic [7:0] OPT_TSTAMP     = 8'd8;
  localparam logic [7:0] OPT_LAST_KIND  = 8'd255;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  int          mismatches;
  int          results_owed;

  int          cycles = 0;
  int          bytes_sent = 0;
  int          burst_left = 0;
  int          ready_pct = 100;
  int          ready_hold = 0;
  logic [7:0]  seg [$];

  tcp_header_option_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  tcp_parse_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .mismatches   (mismatches),
    .results_owed (results_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: stretches of a random ready rate, some of them never stalling
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_pct  = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(5, 95);
      ready_hold = $urandom_range(10, 400);
    end
    ready_hold = ready_hold - 1;
    out_tready <= ($urandom_range(1, 100) <= ready_pct);
  end

  function automatic logic [15:0] any_port();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0)
      return 16'h0000;
    else if (pick == 1)
      return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
    burst_left = burst_left - 1;
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic send_segment();
    foreach (seg[i])
      send_byte(seg[i], i == seg.size() - 1);
    seg.delete();
  endtask

  task automatic put_header(input logic [3:0] offw, input logic [15:0] sp,
                            input logic [15:0] dp);
    logic [7:0] r;
    r = 8'($urandom);
    seg.push_back(sp[15:8]);
    seg.push_back(sp[7:0]);
    seg.push_back(dp[15:8]);
    seg.push_back(dp[7:0]);
    repeat (8) seg.push_back(8'($urandom));
    seg.push_back({offw, r[3:0]});
    repeat (7) seg.push_back(8'($urandom));
  endtask

  task automatic put_option(input logic [7:0] kind_b, input logic [7:0] len_b);
    seg.push_back(kind_b);
    seg.push_back(len_b);
    for (int i = 2; i < len_b && seg.size() < SEG_CAP; i++)
      seg.push_back(8'($urandom));
  endtask

  task automatic random_option(input bit broken);
    logic [7:0] kind_b;
    logic [7:0] len_b;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      seg.push_back((pick == 0) ? tcp_hop_pkg::OPT_EOL : tcp_hop_pkg::OPT_NOP);
    end else begin
      case (pick)
        3:       kind_b = OPT_MSS;
        4:       kind_b = OPT_WSCALE;
        5:       kind_b = OPT_SACK_OK;
        6:       kind_b = OPT_SACK;
        7:       kind_b = OPT_TSTAMP;
        8:       kind_b = 8'($urandom_range(OPT_ECHO, OPT_ECHO_REPLY));
        default: kind_b = 8'($urandom_range(tcp_hop_pkg::KNOWN_KINDS, OPT_LAST_KIND));
      endcase
      if (kind_b >= tcp_hop_pkg::KNOWN_KINDS)
        len_b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(2, 255)) :
                                                8'($urandom_range(2, 10));
      else if (kind_b == OPT_SACK)
        len_b = 8'($urandom_range(2, 18));
      else
        len_b = tcp_hop_pkg::EXPECT_LEN[kind_b];
      if (broken && $urandom_range(0, 4) == 0)
        len_b = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) :
                                       8'($urandom_range(0, 255));
      put_option(kind_b, len_b);
    end
  endtask

  task automatic random_segment();
    logic [3:0] offw;
    int         hlen;
    int         style;
    int         cut;
    style = $urandom_range(0, 99);
    if (style >= 88) begin
      repeat ($urandom_range(1, 70)) seg.push_back(8'($urandom));
    end else if (style >= 80) begin
      put_header(4'($urandom_range(0, tcp_hop_pkg::MIN_OFFSET_WORDS - 1)),
                 any_port(), any_port());
      repeat ($urandom_range(0, 6)) seg.push_back(8'($urandom));
    end else begin
      offw = 4'($urandom_range(tcp_hop_pkg::MIN_OFFSET_WORDS, 15));
      hlen = offw * 4;
      put_header(offw, any_port(), any_port());
      while (seg.size() < hlen) begin
        if (hlen - seg.size() == 1 && $urandom_range(0, 4) != 0)
          seg.push_back(tcp_hop_pkg::OPT_NOP);
        else
          random_option(style >= 60 && style < 70);
      end
      repeat ($urandom_range(0, 6)) seg.push_back(8'($urandom));
      // truncated, sometimes below the fixed header
      if (style >= 70) begin
        cut = $urandom_range(1, hlen - 1);
        while (seg.size() > cut) void'(seg.pop_back());
      end
    end
    send_segment();
  endtask

  initial begin
    int start_count;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte segments, byte extremes
    seg.push_back(8'hFF);
    send_segment();
    seg.push_back(8'h00);
    send_segment();

    // bare header, port extremes
    put_header(4'd5, 16'hFFFF, 16'h0000);
    send_segment();

    // full option area with every known kind but echo reply, and an unknown one
    put_header(4'd15, 16'h0000, 16'hFFFF);
    seg.push_back(tcp_hop_pkg::OPT_EOL);
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    put_option(OPT_MSS, tcp_hop_pkg::EXPECT_LEN[OPT_MSS]);
    put_option(OPT_WSCALE, tcp_hop_pkg::EXPECT_LEN[OPT_WSCALE]);
    put_option(OPT_SACK_OK, tcp_hop_pkg::EXPECT_LEN[OPT_SACK_OK]);
    put_option(OPT_SACK, 8'd10);
    put_option(OPT_TSTAMP, tcp_hop_pkg::EXPECT_LEN[OPT_TSTAMP]);
    put_option(8'd200, 8'd3);
    put_option(OPT_ECHO, tcp_hop_pkg::EXPECT_LEN[OPT_ECHO]);
    seg.push_back(8'($urandom));
    seg.push_back(8'($urandom));
    send_segment();

    // record and summary on the same byte
    put_header(4'd6, any_port(), any_port());
    repeat (4) seg.push_back(tcp_hop_pkg::OPT_NOP);
    send_segment();

    // length byte below two aborts
    put_header(4'd6, any_port(), any_port());
    put_option(OPT_MSS, 8'd1);
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    seg.push_back(8'($urandom));
    send_segment();

    // fixed length mismatch aborts
    put_header(4'd6, any_port(), any_port());
    put_option(OPT_MSS, 8'd5);
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    send_segment();

    // kind on the final option byte
    put_header(4'd6, any_port(), any_port());
    repeat (3) seg.push_back(tcp_hop_pkg::OPT_NOP);
    put_option(OPT_WSCALE, tcp_hop_pkg::EXPECT_LEN[OPT_WSCALE]);
    send_segment();

    // value running past the header end
    put_header(4'd6, any_port(), any_port());
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    put_option(OPT_TSTAMP, tcp_hop_pkg::EXPECT_LEN[OPT_TSTAMP]);
    send_segment();

    // unknown kind with empty value, then parsing goes on
    put_header(4'd6, any_port(), any_port());
    put_option(OPT_LAST_KIND, tcp_hop_pkg::KIND_LEN_BYTES);
    seg.push_back(tcp_hop_pkg::OPT_NOP);
    seg.push_back(tcp_hop_pkg::OPT_EOL);
    send_segment();

    // truncated inside the option area
    put_header(4'd8, any_port(), any_port());
    repeat (3) seg.push_back(tcp_hop_pkg::OPT_NOP);
    send_segment();

    // bad offsets, with and without payload
    put_header(4'd4, any_port(), any_port());
    repeat (3) seg.push_back(8'($urandom));
    send_segment();
    put_header(4'd0, any_port(), any_port());
    send_segment();

    // nineteen bytes: too short
    put_header(4'd5, any_port(), any_port());
    void'(seg.pop_back());
    send_segment();

    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES)
      random_segment();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && results_owed == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
